### src/ycc2rgb_pkg.sv
// Package with the shared constants, types and color helpers of the block to pixel converter.
package ycc2rgb_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 12;
  localparam int CFG_W    = 13;
  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 8;
  localparam int CFG_IDX_W = 1;

  // Block geometry.
  localparam int BLOCK_SIZE = 8;
  localparam int BLK_SHIFT  = 3;
  localparam int IDX_W      = 6;

  // Fixed-point color arithmetic in Q14.
  localparam int Q_BITS = 14;
  localparam int SUM_W  = 28;

  typedef logic signed [SUM_W-1:0] csum_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COLOR_W-1:0] color_t;

  localparam csum_t COEF_R_CR    = csum_t'(22970);
  localparam csum_t COEF_G_CB    = csum_t'(5638);
  localparam csum_t COEF_G_CR    = csum_t'(11700);
  localparam csum_t COEF_B_CB    = csum_t'(29032);
  localparam csum_t COLOR_OFFSET = csum_t'(128);
  localparam color_t COLOR_MAX   = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

  // Floor of a Q14 sum, clamped to the 0..255 range.
  function automatic color_t to_byte(input csum_t sum);
    color_t res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:Q_BITS+COLOR_W]) begin
      res = COLOR_MAX;
    end else begin
      res = sum[Q_BITS+COLOR_W-1:Q_BITS];
    end
    return res;
  endfunction

endpackage

### src/ycbcr444_block_to_rgb_pixels.sv
// Top level of the YCbCr 4:4:4 block sample to RGB pixel converter.
// Samples of 8x8 blocks arrive one word per cycle while in_ready is high, 64 per block,
// blocks in raster order, and the block keeps the position of the next sample itself. Each
// word is placed at column k mod 8 and at row 7 - k div 8 of its block (rows are flipped),
// words whose pixel falls outside the configured image size are dropped without a result,
// and kept words come out as one clamped RGB word with the pixel coordinates. The block
// takes one word every cycle unless out_ready holds it back; a result leaves through an
// input stage and a result register, each holding one word. The user must write the image
// size through the configuration port only while no words are in flight, which the block
// does not check; a size of zero acts as one and a size above MAX_DIM acts as MAX_DIM.
module ycbcr444_block_to_rgb_pixels #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ycc2rgb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ycc2rgb_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ycc2rgb_pkg::SAMPLE_W-1:0] in_luma_sample,
  input  logic signed [ycc2rgb_pkg::SAMPLE_W-1:0] in_blue_chroma,
  input  logic signed [ycc2rgb_pkg::SAMPLE_W-1:0] in_red_chroma,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ycc2rgb_pkg::COORD_W-1:0]        out_pixel_x,
  output logic [ycc2rgb_pkg::COORD_W-1:0]        out_pixel_y,
  output logic [ycc2rgb_pkg::COLOR_W-1:0]        out_red_out,
  output logic [ycc2rgb_pkg::COLOR_W-1:0]        out_green_out,
  output logic [ycc2rgb_pkg::COLOR_W-1:0]        out_blue_out
);
  import ycc2rgb_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int NBLK  = (MAX_DIM + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int COL_W = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int XW    = COL_W + BLK_SHIFT;
  localparam int PW    = (XW > COORD_W) ? XW : COORD_W;
  localparam int EW    = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int CW    = (PW > DIM_W) ? PW : DIM_W;
  localparam logic [IDX_W-1:0] LAST_IDX = {IDX_W{1'b1}};

  // Effective image size: zero acts as one, values above the maximum are capped.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (EW'(v) > EW'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [COL_W:0] blk_count(input logic [DIM_W-1:0] dim);
    logic [DIM_W:0] tmp;
    tmp = (DIM_W+1)'(dim) + (DIM_W+1)'(BLOCK_SIZE - 1);
    return (COL_W+1)'(tmp >> BLK_SHIFT);
  endfunction

  // Image size and block counts, kept ready for use.
  logic [DIM_W-1:0] width_r, height_r;
  logic [COL_W:0]   cols_r, rows_r;

  // Position of the next sample.
  logic [IDX_W-1:0] idx_r;
  logic [COL_W-1:0] col_r, row_r;

  // Input stage.
  logic           s1_valid_r;
  sample_t        s1_luma_r, s1_cb_r, s1_cr_r;
  logic [XW-1:0]  s1_x_r, s1_y_r;

  // Result register.
  logic           out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  color_t         out_red_r, out_green_r, out_blue_r;

  logic           in_fire;
  logic           s1_ready;
  logic [XW-1:0]  pos_x, pos_y;
  logic           keep;
  logic [PW-1:0]  s1_x_ext, s1_y_ext;
  csum_t          base, sum_r, sum_g, sum_b;

  assign s1_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_ready;
  assign in_fire  = in_valid && in_ready;

  // Row index inside the block is flipped: 7 - k div 8 is the inverse of the upper bits.
  assign pos_x = {col_r, idx_r[BLK_SHIFT-1:0]};
  assign pos_y = {row_r, ~idx_r[IDX_W-1:BLK_SHIFT]};
  assign keep  = (CW'(pos_x) < CW'(width_r)) && (CW'(pos_y) < CW'(height_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= eff_dim(DIM_RESET);
      height_r <= eff_dim(DIM_RESET);
      cols_r   <= blk_count(eff_dim(DIM_RESET));
      rows_r   <= blk_count(eff_dim(DIM_RESET));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= eff_dim(cfg_data);
          cols_r  <= blk_count(eff_dim(cfg_data));
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= eff_dim(cfg_data);
          rows_r   <= blk_count(eff_dim(cfg_data));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      idx_r <= idx_r + IDX_W'(1);
      if (idx_r == LAST_IDX) begin
        // A column or row left beyond a smaller new size wraps here as well.
        if ((COL_W+1)'(col_r) + (COL_W+1)'(1) >= cols_r) begin
          col_r <= '0;
          if ((COL_W+1)'(row_r) + (COL_W+1)'(1) >= rows_r) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + COL_W'(1);
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_fire && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_luma_r <= in_luma_sample;
      s1_cb_r   <= in_blue_chroma;
      s1_cr_r   <= in_red_chroma;
      s1_x_r    <= pos_x;
      s1_y_r    <= pos_y;
    end
  end

  always_comb begin
    base  = (csum_t'(s1_luma_r) + COLOR_OFFSET) <<< Q_BITS;
    sum_r = base + csum_t'(s1_cr_r) * COEF_R_CR;
    sum_g = base - csum_t'(s1_cb_r) * COEF_G_CB - csum_t'(s1_cr_r) * COEF_G_CR;
    sum_b = base + csum_t'(s1_cb_r) * COEF_B_CB;
  end

  assign s1_x_ext = PW'(s1_x_r);
  assign s1_y_ext = PW'(s1_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid_r) begin
      out_x_r     <= s1_x_ext[COORD_W-1:0];
      out_y_r     <= s1_y_ext[COORD_W-1:0];
      out_red_r   <= to_byte(sum_r);
      out_green_r <= to_byte(sum_g);
      out_blue_r  <= to_byte(sum_b);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_x   = out_x_r;
  assign out_pixel_y   = out_y_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

`ifndef SYNTH
  // The last sample of a block always brings the index back to the first one.
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && idx_r == LAST_IDX) |=> (idx_r == '0))
    else $error("sample index did not wrap after the last sample of a block");

  // The block row moves only when the block column wraps.
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (idx_r != LAST_IDX ||
                 (COL_W+1)'(col_r) + (COL_W+1)'(1) < cols_r)) |=> $stable(row_r))
    else $error("block row changed without a column wrap");

  // Only samples inside the image reach the input stage.
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((CW'(s1_x_r) < CW'(width_r)) && (CW'(s1_y_r) < CW'(height_r))))
    else $error("input stage holds a sample outside the image");

  // With the result register empty, the converter must take a new word.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the result register was empty");
`endif

endmodule
